>>> rtl/aob_pkg.sv
// ----------------------------------------------------------------------------
// aob_pkg: shared types and constants for the Annex B OBU deframer
// Codes for byte roles, error causes and parse phases, plus the result word
// handed from the parse step to the output register.
// ----------------------------------------------------------------------------
package aob_pkg;

  // Default limits: longest leb128 field in bytes, width of a decoded size
  localparam int LEB_MAX_BYTES = 8;
  localparam int SIZE_BITS     = 32;

  // Leb128 byte layout
  localparam logic [7:0] LEB_MORE_MASK = 8'h80;
  localparam logic [7:0] LEB_BITS_MASK = 8'h7f;
  localparam int         LEB_BITS      = 7;

  typedef enum logic [1:0] {
    PH_TU_SIZE  = 2'd0,
    PH_FU_SIZE  = 2'd1,
    PH_OBU_SIZE = 2'd2,
    PH_PAYLOAD  = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    ROLE_TU_SIZE  = 3'd0,
    ROLE_FU_SIZE  = 3'd1,
    ROLE_OBU_SIZE = 3'd2,
    ROLE_PAYLOAD  = 3'd3,
    ROLE_END      = 3'd4,
    ROLE_ERROR    = 3'd5
  } role_e;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_LEB      = 3'd1,
    ERR_FU_SIZE  = 3'd2,
    ERR_OBU_SIZE = 3'd3,
    ERR_TRUNC    = 3'd4
  } err_e;

  // Stream word kinds
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_EOS  = 1'b1;

  // Status of one leb128 byte
  typedef struct packed {
    logic bad;   // malformed or too large
    logic more;  // continuation bit set, field not complete
  } leb_status_t;

  // One result word
  typedef struct packed {
    logic [7:0] out_byte;
    role_e      role;
    logic       obu_start;
    logic       obu_end;
    logic       fu_end;
    logic       tu_end;
    err_e       err;
  } result_t;

endpackage

>>> rtl/aob_leb.sv
// ----------------------------------------------------------------------------
// aob_leb: leb128 byte accumulator
// Merges one leb128 byte into the partial size value and flags overflow,
// an over-long field and whether more bytes follow.
// ----------------------------------------------------------------------------
module aob_leb #(
  parameter int LebMaxBytes = aob_pkg::LEB_MAX_BYTES,
  parameter int SizeBits    = aob_pkg::SIZE_BITS,
  localparam int CntW       = $clog2(LebMaxBytes + 1),
  localparam int ShW        = $clog2(aob_pkg::LEB_BITS * LebMaxBytes)
) (
  input  logic [7:0]          byte_i,
  input  logic [CntW-1:0]     count_i,
  input  logic [SizeBits-1:0] value_i,
  output logic [SizeBits-1:0] value_o,
  output logic [CntW-1:0]     count_o,
  output aob_pkg::leb_status_t status_o
);

  logic [6:0]                 bits;
  logic [ShW-1:0]             shift;
  logic [SizeBits+6:0]        placed;
  logic [SizeBits-1:0]        base;
  logic                       overflow;

  // Place the seven value bits at their weight
  always_comb begin
    bits     = 7'(byte_i & aob_pkg::LEB_BITS_MASK);
    shift    = ShW'(aob_pkg::LEB_BITS) * ShW'(count_i);
    placed   = {{SizeBits{1'b0}}, bits} << shift;
    base     = (count_i == '0) ? '0 : value_i;
    overflow = (32'(shift) >= 32'(SizeBits)) ? (bits != '0)
                                              : (|placed[SizeBits+6:SizeBits]);
  end

  // Merge, count and check the length limit
  always_comb begin
    value_o        = base | placed[SizeBits-1:0];
    count_o        = count_i + CntW'(1);
    status_o.more  = (byte_i & aob_pkg::LEB_MORE_MASK) != 8'h00;
    status_o.bad   = overflow ||
                     (status_o.more && (32'(count_o) >= 32'(LebMaxBytes)));
  end

endmodule

>>> rtl/aob_step.sv
// ----------------------------------------------------------------------------
// aob_step: parse state and per-word step logic
// Holds the unit counters, the leb128 accumulator and the sticky error, and
// turns one stream word into one tagged result word.
// ----------------------------------------------------------------------------
module aob_step #(
  parameter int LebMaxBytes = aob_pkg::LEB_MAX_BYTES,
  parameter int SizeBits    = aob_pkg::SIZE_BITS,
  localparam int CntW       = $clog2(LebMaxBytes + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic             kind_i,
  input  logic [7:0]       byte_i,
  output aob_pkg::result_t res_o
);

  aob_pkg::phase_e       phase_q, phase_d;
  logic [SizeBits-1:0]   tu_q, tu_d;
  logic [SizeBits-1:0]   fu_q, fu_d;
  logic [SizeBits-1:0]   obu_q, obu_d;
  logic [SizeBits-1:0]   leb_value_q, leb_value_d;
  logic [CntW-1:0]       leb_count_q, leb_count_d;
  aob_pkg::err_e         err_q, err_d;

  logic [SizeBits-1:0]   leb_value;
  logic [CntW-1:0]       leb_count;
  aob_pkg::leb_status_t  leb_status;
  logic [SizeBits:0]     total;

  aob_leb #(
    .LebMaxBytes(LebMaxBytes),
    .SizeBits   (SizeBits)
  ) u_leb (
    .byte_i  (byte_i),
    .count_i (leb_count_q),
    .value_i (leb_value_q),
    .value_o (leb_value),
    .count_o (leb_count),
    .status_o(leb_status)
  );

  // Phase after a unit boundary: whichever enclosing unit still has room
  function automatic aob_pkg::phase_e after_unit(logic fu_zero, logic tu_zero);
    aob_pkg::phase_e ph;
    if (tu_zero) begin
      ph = aob_pkg::PH_TU_SIZE;
    end else if (fu_zero) begin
      ph = aob_pkg::PH_FU_SIZE;
    end else begin
      ph = aob_pkg::PH_OBU_SIZE;
    end
    return ph;
  endfunction

  // Size of a unit plus the bytes of its size field
  assign total = (SizeBits+1)'(leb_value) + (SizeBits+1)'(leb_count);

  // Next state and result for the word in hand
  always_comb begin
    phase_d     = phase_q;
    tu_d        = tu_q;
    fu_d        = fu_q;
    obu_d       = obu_q;
    leb_value_d = leb_value_q;
    leb_count_d = leb_count_q;
    err_d       = err_q;
    res_o       = '0;

    if (kind_i == aob_pkg::KIND_EOS) begin
      // Close the stream and return to reset
      if (err_q != aob_pkg::ERR_NONE) begin
        res_o.role = aob_pkg::ROLE_ERROR;
        res_o.err  = err_q;
      end else if (phase_q != aob_pkg::PH_TU_SIZE || leb_count_q != '0) begin
        res_o.role = aob_pkg::ROLE_ERROR;
        res_o.err  = aob_pkg::ERR_TRUNC;
      end else begin
        res_o.role = aob_pkg::ROLE_END;
      end
      phase_d     = aob_pkg::PH_TU_SIZE;
      tu_d        = '0;
      fu_d        = '0;
      obu_d       = '0;
      leb_value_d = '0;
      leb_count_d = '0;
      err_d       = aob_pkg::ERR_NONE;
    end else if (err_q != aob_pkg::ERR_NONE) begin
      // Sticky error: pass the byte, tag it
      res_o.out_byte = byte_i;
      res_o.role     = aob_pkg::ROLE_ERROR;
      res_o.err      = err_q;
    end else if (phase_q == aob_pkg::PH_PAYLOAD) begin
      // Payload: count down all three units
      res_o.out_byte  = byte_i;
      res_o.role      = aob_pkg::ROLE_PAYLOAD;
      res_o.obu_start = (obu_q == leb_value_q);
      obu_d = obu_q - SizeBits'(1);
      fu_d  = fu_q - SizeBits'(1);
      tu_d  = tu_q - SizeBits'(1);
      if (obu_d == '0) begin
        res_o.obu_end = 1'b1;
        res_o.fu_end  = (fu_d == '0);
        res_o.tu_end  = (tu_d == '0);
        phase_d       = after_unit(fu_d == '0, tu_d == '0);
      end
    end else begin
      // Size field byte of the current phase
      res_o.out_byte = byte_i;
      unique case (phase_q)
        aob_pkg::PH_TU_SIZE: res_o.role = aob_pkg::ROLE_TU_SIZE;
        aob_pkg::PH_FU_SIZE: res_o.role = aob_pkg::ROLE_FU_SIZE;
        default:             res_o.role = aob_pkg::ROLE_OBU_SIZE;
      endcase
      if (leb_status.bad) begin
        err_d      = aob_pkg::ERR_LEB;
        res_o.role = aob_pkg::ROLE_ERROR;
        res_o.err  = aob_pkg::ERR_LEB;
      end else if (leb_status.more) begin
        leb_value_d = leb_value;
        leb_count_d = leb_count;
      end else begin
        leb_value_d = leb_value;
        leb_count_d = '0;
        unique case (phase_q)
          aob_pkg::PH_TU_SIZE: begin
            tu_d = leb_value;
            if (leb_value == '0) begin
              res_o.tu_end = 1'b1;
            end else begin
              phase_d = aob_pkg::PH_FU_SIZE;
            end
          end
          aob_pkg::PH_FU_SIZE: begin
            if (total > {1'b0, tu_q}) begin
              err_d      = aob_pkg::ERR_FU_SIZE;
              res_o.role = aob_pkg::ROLE_ERROR;
              res_o.err  = aob_pkg::ERR_FU_SIZE;
            end else begin
              tu_d = tu_q - SizeBits'(leb_count);
              fu_d = leb_value;
              if (leb_value == '0) begin
                res_o.fu_end = 1'b1;
                res_o.tu_end = (tu_d == '0);
                phase_d      = after_unit(1'b1, tu_d == '0);
              end else begin
                phase_d = aob_pkg::PH_OBU_SIZE;
              end
            end
          end
          default: begin
            if (total > {1'b0, fu_q}) begin
              err_d      = aob_pkg::ERR_OBU_SIZE;
              res_o.role = aob_pkg::ROLE_ERROR;
              res_o.err  = aob_pkg::ERR_OBU_SIZE;
            end else begin
              tu_d  = tu_q - SizeBits'(leb_count);
              fu_d  = fu_q - SizeBits'(leb_count);
              obu_d = leb_value;
              if (leb_value == '0) begin
                res_o.obu_end = 1'b1;
                res_o.fu_end  = (fu_d == '0);
                res_o.tu_end  = (tu_d == '0);
                phase_d       = after_unit(fu_d == '0, tu_d == '0);
              end else begin
                phase_d = aob_pkg::PH_PAYLOAD;
              end
            end
          end
        endcase
      end
    end
  end

  // Advance the parse state once per word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= aob_pkg::PH_TU_SIZE;
      tu_q        <= '0;
      fu_q        <= '0;
      obu_q       <= '0;
      leb_value_q <= '0;
      leb_count_q <= '0;
      err_q       <= aob_pkg::ERR_NONE;
    end else if (step_i) begin
      phase_q     <= phase_d;
      tu_q        <= tu_d;
      fu_q        <= fu_d;
      obu_q       <= obu_d;
      leb_value_q <= leb_value_d;
      leb_count_q <= leb_count_d;
      err_q       <= err_d;
    end
  end

endmodule

>>> rtl/annexb_obu_deframer.sv
// ----------------------------------------------------------------------------
// annexb_obu_deframer: AV1 Annex B deframer, one byte per word
// Parses nested temporal-unit, frame-unit and OBU sizes and tags each byte.
// ----------------------------------------------------------------------------
// The block takes one stream word per clock cycle and returns exactly one
// result word for it, in order. A word passes through two registers: the
// input register, then the result register; the parse step between them
// updates the unit counters as the word moves on, and throughput is one word
// per cycle while the downstream side takes results. The result register and
// the input register together absorb a stall, and s_axis_tready drops only
// once both hold a word. Errors stay latched until an end-of-stream word,
// which also returns all parse state to its reset values.
module annexb_obu_deframer #(
  parameter int LebMaxBytes = aob_pkg::LEB_MAX_BYTES,
  parameter int SizeBits    = aob_pkg::SIZE_BITS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // Input stream
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  logic       s_axis_tuser,   // [0] kind
  // Result stream
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic [8:0] m_axis_tuser,   // [2:0] role, [3] obu_start, [4] obu_end,
                                     // [5] frame_unit_end, [8:6] error_code
  output logic       m_axis_tlast    // temporal_unit_end
);

  logic             in_valid_q, in_valid_d;
  logic             in_kind_q;
  logic [7:0]       in_byte_q;
  logic             out_valid_q, out_valid_d;
  aob_pkg::result_t out_res_q;
  aob_pkg::result_t step_res;
  logic             advance;
  logic             in_take;

  // Move a word on when the result register is free or being emptied
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  aob_step #(
    .LebMaxBytes(LebMaxBytes),
    .SizeBits   (SizeBits)
  ) u_step (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .step_i(advance),
    .kind_i(in_kind_q),
    .byte_i(in_byte_q),
    .res_o (step_res)
  );

  // Valid flags
  always_comb begin
    in_valid_d = in_take ? 1'b1 : (advance ? 1'b0 : in_valid_q);
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Capture input word and result word
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_kind_q <= s_axis_tuser;
      in_byte_q <= s_axis_tdata;
    end
    if (advance) begin
      out_res_q <= step_res;
    end
  end

  // Drive the result stream
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_res_q.out_byte;
  assign m_axis_tuser  = {out_res_q.err, out_res_q.fu_end, out_res_q.obu_end,
                          out_res_q.obu_start, out_res_q.role};
  assign m_axis_tlast  = out_res_q.tu_end;

  // An empty result register never blocks the input side
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> s_axis_tready)
    else $error("input stalled with empty result register");

  // Error role and error code agree
  a_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((out_res_q.role == aob_pkg::ROLE_ERROR) ==
                     (out_res_q.err != aob_pkg::ERR_NONE)))
    else $error("error role and code disagree");

  // OBU start only on payload bytes
  a_start_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_res_q.obu_start) |-> out_res_q.role == aob_pkg::ROLE_PAYLOAD)
    else $error("obu_start outside payload");

  // Unit end marks never on end-of-stream or error words
  a_marks_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_res_q.obu_end || out_res_q.fu_end || out_res_q.tu_end)) |->
    (out_res_q.role != aob_pkg::ROLE_ERROR && out_res_q.role != aob_pkg::ROLE_END))
    else $error("unit end mark on end or error word");

  // A word in the input register moves on as soon as the output side frees
  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && m_axis_tready) |=> out_valid_q)
    else $error("word not advanced into result register");

endmodule

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the Annex B OBU deframer
// Drives a table of hand-made streams, then random temporal units built from
// random frame units and OBUs, some of them cut short, corrupted or replaced
// by noise. Each result word is checked against its typed table row or a parse predictor.
// ----------------------------------------------------------------------------
module tb;
  import aob_pkg::*;

  localparam int SizeW  = aob_pkg::SIZE_BITS;
  localparam int LebMax = aob_pkg::LEB_MAX_BYTES;

  // One row of the directed table; marks are {obu_start, obu_end, fu_end, tu_end}
  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic       typed;
    role_e      role;
    logic [3:0] marks;
    err_e       err;
  } dir_row_t;

  localparam int DirCount = 31;
  localparam dir_row_t DirRows [DirCount] = '{
    '{KIND_EOS,  8'h00, 1'b1, ROLE_END,     4'b0000, ERR_NONE},     // end right after reset
    '{KIND_BYTE, 8'h00, 1'b1, ROLE_TU_SIZE, 4'b0001, ERR_NONE},     // empty temporal unit
    '{KIND_BYTE, 8'h06, 1'b0, ROLE_TU_SIZE, 4'b0000, ERR_NONE},
    '{KIND_BYTE, 8'h00, 1'b0, ROLE_TU_SIZE, 4'b0000, ERR_NONE},     // empty frame unit
    '{KIND_BYTE, 8'h04, 1'b0, ROLE_TU_SIZE, 4'b0000, ERR_NONE},
    '{KIND_BYTE, 8'h00, 1'b0, ROLE_TU_SIZE, 4'b0000, ERR_NONE},     // empty OBU
    '{KIND_BYTE, 8'h02, 1'b0, ROLE_TU_SIZE, 4'b0000, ERR_NONE},
    '{KIND_BYTE, 8'hff, 1'b0, ROLE_TU_SIZE, 4'b0000, ERR_NONE},
    '{KIND_BYTE, 8'h00, 1'b0, ROLE_TU_SIZE, 4'b0000, ERR_NONE},     // closes all three units
    '{KIND_EOS,  8'hff, 1'b1, ROLE_END,     4'b0000, ERR_NONE},
    '{KIND_BYTE, 8'h80, 1'b0, ROLE_TU_SIZE, 4'b0000, ERR_NONE},
    '{KIND_EOS,  8'h00, 1'b1, ROLE_ERROR,   4'b0000, ERR_TRUNC},    // end inside a size
    '{KIND_BYTE, 8'h02, 1'b0, ROLE_TU_SIZE, 4'b0000, ERR_NONE},
    '{KIND_BYTE, 8'h02, 1'b1, ROLE_ERROR,   4'b0000, ERR_FU_SIZE},  // frame unit too big
    '{KIND_BYTE, 8'h33, 1'b1, ROLE_ERROR,   4'b0000, ERR_FU_SIZE},  // error stays latched
    '{KIND_EOS,  8'h00, 1'b1, ROLE_ERROR,   4'b0000, ERR_FU_SIZE},
    '{KIND_BYTE, 8'h05, 1'b0, ROLE_TU_SIZE, 4'b0000, ERR_NONE},
    '{KIND_BYTE, 8'h04, 1'b0, ROLE_TU_SIZE, 4'b0000, ERR_NONE},
    '{KIND_BYTE, 8'h04, 1'b1, ROLE_ERROR,   4'b0000, ERR_OBU_SIZE}, // OBU too big
    '{KIND_EOS,  8'h00, 1'b1, ROLE_ERROR,   4'b0000, ERR_OBU_SIZE},
    '{KIND_BYTE, 8'hff, 1'b0, ROLE_TU_SIZE, 4'b0000, ERR_NONE},     // largest temporal unit
    '{KIND_BYTE, 8'hff, 1'b0, ROLE_TU_SIZE, 4'b0000, ERR_NONE},
    '{KIND_BYTE, 8'hff, 1'b0, ROLE_TU_SIZE, 4'b0000, ERR_NONE},
    '{KIND_BYTE, 8'hff, 1'b0, ROLE_TU_SIZE, 4'b0000, ERR_NONE},
    '{KIND_BYTE, 8'h0f, 1'b0, ROLE_TU_SIZE, 4'b0000, ERR_NONE},
    '{KIND_BYTE, 8'hff, 1'b0, ROLE_TU_SIZE, 4'b0000, ERR_NONE},     // frame size over 32 bits
    '{KIND_BYTE, 8'hff, 1'b0, ROLE_TU_SIZE, 4'b0000, ERR_NONE},
    '{KIND_BYTE, 8'hff, 1'b0, ROLE_TU_SIZE, 4'b0000, ERR_NONE},
    '{KIND_BYTE, 8'hff, 1'b0, ROLE_TU_SIZE, 4'b0000, ERR_NONE},
    '{KIND_BYTE, 8'h1f, 1'b1, ROLE_ERROR,   4'b0000, ERR_LEB},
    '{KIND_EOS,  8'h00, 1'b1, ROLE_ERROR,   4'b0000, ERR_LEB}
  };

  logic       clk_i;
  logic       rst_ni;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;   // [7:0] data_byte
  logic       s_axis_tuser;   // [0] kind
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata;   // [7:0] out_byte
  logic [8:0] m_axis_tuser;   // [2:0] role, [3] obu_start, [4] obu_end,
                              // [5] frame_unit_end, [8:6] error_code
  logic       m_axis_tlast;   // temporal_unit_end

  // Predictor state
  phase_e            ph;
  logic [SizeW-1:0]  tu_rem, fu_rem, obu_rem, leb_val;
  int unsigned       leb_cnt;
  err_e              err_held;

  result_t     tagged_q[$];
  int unsigned mismatches;
  int unsigned words_seen;
  bit          steady;
  bit          drain_all;
  int unsigned ready_left;

  annexb_obu_deframer u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Bound the run
  initial begin
    #3000000;
    $display("[annexb_obu_deframer] ERROR");
    $finish;
  end

  task automatic note_fault(input string msg);
    $display("MISMATCH word %0d: %s", words_seen, msg);
    mismatches++;
  endtask

  function automatic void clear_parse();
    ph       = PH_TU_SIZE;
    tu_rem   = '0;
    fu_rem   = '0;
    obu_rem  = '0;
    leb_val  = '0;
    leb_cnt  = 0;
    err_held = ERR_NONE;
  endfunction

  // Mark exhausted units and pick the next size to parse
  function automatic void close_units(inout result_t r);
    if (fu_rem == 0) r.fu_end = 1'b1;
    if (tu_rem == 0) r.tu_end = 1'b1;
    ph = (tu_rem == 0) ? PH_TU_SIZE : ((fu_rem == 0) ? PH_FU_SIZE : PH_OBU_SIZE);
  endfunction

  // Tag one stream word and advance the parse state
  function automatic result_t deframe_step(input logic kind, input logic [7:0] b);
    result_t        r;
    logic [6:0]     bits;
    int unsigned    i;
    int unsigned    shift;
    logic           bad;
    logic [SizeW:0] total;
    r = '0;
    if (kind == KIND_EOS) begin
      if (err_held != ERR_NONE) begin
        r.role = ROLE_ERROR;
        r.err  = err_held;
      end else if (ph != PH_TU_SIZE || leb_cnt != 0) begin
        r.role = ROLE_ERROR;
        r.err  = ERR_TRUNC;
      end else begin
        r.role = ROLE_END;
      end
      clear_parse();
      return r;
    end
    r.out_byte = b;
    if (err_held != ERR_NONE) begin
      r.role = ROLE_ERROR;
      r.err  = err_held;
      return r;
    end
    if (ph == PH_PAYLOAD) begin
      r.role      = ROLE_PAYLOAD;
      r.obu_start = (obu_rem == leb_val);
      obu_rem--;
      fu_rem--;
      tu_rem--;
      if (obu_rem == 0) begin
        r.obu_end = 1'b1;
        close_units(r);
      end
      return r;
    end
    r.role = role_e'({1'b0, ph});
    // Gather leb128 bits; reject value bits beyond the size width
    bits  = b[6:0];
    i     = leb_cnt;
    shift = LEB_BITS * i;
    bad   = 1'b0;
    if (i == 0) leb_val = '0;
    if (shift >= SizeW) begin
      bad = (bits != 0);
    end else if (SizeW - shift < LEB_BITS && (bits >> (SizeW - shift)) != 0) begin
      bad = 1'b1;
    end else begin
      leb_val = leb_val | (SizeW'(bits) << shift);
    end
    if (!bad) begin
      i++;
      bad = (i >= LebMax) && b[7];
    end
    if (bad) begin
      err_held = ERR_LEB;
      r.role   = ROLE_ERROR;
      r.err    = ERR_LEB;
      return r;
    end
    leb_cnt = i;
    if (b[7]) return r;
    // Size complete: check it against the enclosing unit
    total   = leb_val + i;
    leb_cnt = 0;
    case (ph)
      PH_TU_SIZE: begin
        tu_rem = leb_val;
        if (leb_val == 0) r.tu_end = 1'b1;
        else ph = PH_FU_SIZE;
      end
      PH_FU_SIZE: begin
        if (total > tu_rem) begin
          err_held = ERR_FU_SIZE;
          r.role   = ROLE_ERROR;
          r.err    = ERR_FU_SIZE;
          return r;
        end
        tu_rem = tu_rem - i;
        fu_rem = leb_val;
        if (leb_val == 0) close_units(r);
        else ph = PH_OBU_SIZE;
      end
      default: begin
        if (total > fu_rem) begin
          err_held = ERR_OBU_SIZE;
          r.role   = ROLE_ERROR;
          r.err    = ERR_OBU_SIZE;
          return r;
        end
        tu_rem  = tu_rem - i;
        fu_rem  = fu_rem - i;
        obu_rem = leb_val;
        if (leb_val == 0) begin
          r.obu_end = 1'b1;
          close_units(r);
        end else begin
          ph = PH_PAYLOAD;
        end
      end
    endcase
    return r;
  endfunction

  // Append a leb128 size, optionally padded with empty continuation bytes
  task automatic put_leb(ref logic [7:0] q[$], input int unsigned val, input bit padded);
    int unsigned n;
    int unsigned len;
    n = 1;
    while ((val >> (LEB_BITS * n)) != 0) n++;
    len = padded ? $urandom_range(n + 1, LebMax) : n;
    for (int unsigned k = 0; k < len; k++) begin
      q.push_back({k < len - 1, 7'(val >> (LEB_BITS * k))});
    end
  endtask

  // Offer one word after a random gap; called and returning at a falling edge
  task automatic send_word(input logic kind, input logic [7:0] data, input bit typed,
                           input result_t want);
    int unsigned gap;
    int unsigned r;
    result_t     tag;
    gap = 0;
    if (!steady) begin
      r = $urandom_range(0, 99);
      if (r >= 93) gap = $urandom_range(8, 30);
      else if (r >= 65) gap = $urandom_range(1, 3);
    end
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= kind;
    do @(posedge clk_i); while (!s_axis_tready);
    tag = deframe_step(kind, data);
    tagged_q.push_back(typed ? want : tag);
    @(negedge clk_i);
  endtask

  // Result side back-pressure: alternate ready runs and stalls
  always @(negedge clk_i) begin
    if (drain_all) begin
      m_axis_tready <= 1'b1;
    end else if (ready_left != 0) begin
      ready_left--;
    end else if (m_axis_tready) begin
      m_axis_tready <= 1'b0;
      ready_left = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 40) : $urandom_range(0, 2);
    end else begin
      m_axis_tready <= 1'b1;
      ready_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                               : $urandom_range(0, 11);
    end
  end

  // Check each result word against the oldest expectation
  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.out_byte  = m_axis_tdata;
      got.role      = role_e'(m_axis_tuser[2:0]);
      got.obu_start = m_axis_tuser[3];
      got.obu_end   = m_axis_tuser[4];
      got.fu_end    = m_axis_tuser[5];
      got.tu_end    = m_axis_tlast;
      got.err       = err_e'(m_axis_tuser[8:6]);
      if (tagged_q.size() == 0) begin
        note_fault($sformatf("word %h/%h with nothing expected", m_axis_tdata, m_axis_tuser));
      end else begin
        want = tagged_q.pop_front();
        if (got.out_byte !== want.out_byte)
          note_fault($sformatf("byte %h, want %h", got.out_byte, want.out_byte));
        if (got.role !== want.role)
          note_fault($sformatf("role %0d, want %0d", got.role, want.role));
        if (got.obu_start !== want.obu_start)
          note_fault($sformatf("obu_start %b, want %b", got.obu_start, want.obu_start));
        if (got.obu_end !== want.obu_end)
          note_fault($sformatf("obu_end %b, want %b", got.obu_end, want.obu_end));
        if (got.fu_end !== want.fu_end)
          note_fault($sformatf("frame_unit_end %b, want %b", got.fu_end, want.fu_end));
        if (got.tu_end !== want.tu_end)
          note_fault($sformatf("temporal_unit_end %b, want %b", got.tu_end, want.tu_end));
        if (got.err !== want.err)
          note_fault($sformatf("error_code %0d, want %0d", got.err, want.err));
      end
      words_seen++;
    end
  end

  initial begin
    logic [7:0]  stream_bytes[$];
    logic [7:0]  fus[$];
    logic [7:0]  obus[$];
    int unsigned sent;
    int unsigned plen;
    int unsigned sel;
    int unsigned idx;
    result_t     want;
    dir_row_t    row;

    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'h00;
    s_axis_tuser  = KIND_BYTE;
    m_axis_tready = 1'b0;
    rst_ni        = 1'b0;
    mismatches    = 0;
    words_seen    = 0;
    steady        = 1'b0;
    drain_all     = 1'b0;
    ready_left    = 0;
    clear_parse();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Walk the directed table
    for (int d = 0; d < DirCount; d++) begin
      row            = DirRows[d];
      want           = '0;
      want.out_byte  = (row.kind == KIND_EOS) ? 8'h00 : row.data;
      want.role      = row.role;
      {want.obu_start, want.obu_end, want.fu_end, want.tu_end} = row.marks;
      want.err       = row.err;
      send_word(row.kind, row.data, row.typed, want);
    end

    // Random streams: well-formed temporal units, then damage some of them
    sent = 0;
    while (sent < 700) begin
      steady = ($urandom_range(0, 4) == 0);
      stream_bytes.delete();
      repeat ($urandom_range(1, 3)) begin
        fus.delete();
        repeat ($urandom_range(0, 3)) begin
          obus.delete();
          repeat ($urandom_range(0, 3)) begin
            sel  = $urandom_range(0, 99);
            plen = (sel < 55) ? $urandom_range(0, 4) :
                   (sel < 90) ? $urandom_range(5, 20) : $urandom_range(21, 60);
            put_leb(obus, plen, $urandom_range(0, 99) < 15);
            repeat (plen) obus.push_back(8'($urandom));
          end
          put_leb(fus, obus.size(), $urandom_range(0, 99) < 15);
          foreach (obus[k]) fus.push_back(obus[k]);
        end
        put_leb(stream_bytes, fus.size(), $urandom_range(0, 99) < 15);
        foreach (fus[k]) stream_bytes.push_back(fus[k]);
      end

      sel = $urandom_range(0, 99);
      if (sel < 12) begin
        // cut the stream short
        repeat ($urandom_range(1, stream_bytes.size())) begin
          stream_bytes.delete(stream_bytes.size() - 1);
        end
      end else if (sel < 24) begin
        idx = $urandom_range(0, stream_bytes.size() - 1);
        stream_bytes[idx] = stream_bytes[idx] ^ 8'($urandom_range(1, 255));
      end else if (sel < 30) begin
        stream_bytes.insert($urandom_range(0, stream_bytes.size()), 8'($urandom));
      end else if (sel < 36) begin
        // over-long size field, or one with bits beyond the size width
        if ($urandom_range(0, 1) == 1) begin
          repeat (LebMax) stream_bytes.push_back(LEB_MORE_MASK);
        end else begin
          repeat (4) stream_bytes.push_back(8'hff);
          stream_bytes.push_back(8'($urandom_range(16, 127)));
        end
      end else if (sel < 44) begin
        stream_bytes.delete();
        repeat ($urandom_range(1, 24)) stream_bytes.push_back(8'($urandom));
      end

      foreach (stream_bytes[k]) send_word(KIND_BYTE, stream_bytes[k], 1'b0, '0);
      send_word(KIND_EOS, 8'($urandom), 1'b0, '0);
      sent += stream_bytes.size() + 1;
    end

    // Drain, then give stray words a chance to show up
    s_axis_tvalid <= 1'b0;
    drain_all = 1'b1;
    while (tagged_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[annexb_obu_deframer] OK");
    end else begin
      $display("[annexb_obu_deframer] ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/aob_pkg.sv
rtl/aob_leb.sv
rtl/aob_step.sv
rtl/annexb_obu_deframer.sv
tb/sv/tb.sv
